// ===== rtl/core/wav_pcm_resample_to_pwm_unit_defines.svh =====
// Assertion macros used by the PCM resampler top level
`ifndef WAV_PCM_RESAMPLE_TO_PWM_UNIT_DEFINES_SVH
`define WAV_PCM_RESAMPLE_TO_PWM_UNIT_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define WPR_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("wpr: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define WPR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("wpr: next-cycle check failed");

`endif

// ===== rtl/core/wpr_pkg.sv =====
// Shared types, widths and constants of the PCM resampler
`timescale 1ns / 1ps
`default_nettype none

package wpr_pkg;

  // Defaults of the top level parameters
  localparam int OUTPUT_RATE_DEF = 44100;
  localparam int FADE_MS_DEF     = 5;

  // Field and state widths
  localparam int RAW_W   = 32;
  localparam int PCM_W   = 16;
  localparam int LVL_W   = 8;
  localparam int SRC_W   = 17;
  localparam int VOL_W   = 7;
  localparam int FRM_W   = 32;
  localparam int PHASE_W = 18;

  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SIXTEEN_BIT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEREO       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_RATE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VOLUME       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_FRAMES = 3'd4;

  // Reset values of the registers
  localparam int SRC_RATE_RST = 44100;
  localparam int VOLUME_RST   = 70;

  // Fade window: source_rate * fade_ms / 1000, fade_ms up to 50
  localparam int FADE_W    = 6;
  localparam int WPROD_W   = SRC_W + FADE_W;
  localparam int WIN_W     = 13;
  localparam int MS_PER_S  = 1000;
  localparam int WIN_SHIFT = WPROD_W;
  localparam int WIN_RECIP = (1 << WIN_SHIFT) / MS_PER_S;
  localparam int WREC_W    = 14;

  // Gain and sample scaling: sample * volume * gain / (256 * 100)
  localparam int GAIN_W    = 9;
  localparam int GAIN_FULL = 256;
  localparam int DIV_STEPS = 8;
  localparam int VG_W      = 15;
  localparam int MAG_W     = 16;
  localparam int PROD_W    = 30;
  localparam int LO_SHIFT  = 8;
  localparam int Y_W       = PROD_W - LO_SHIFT;
  localparam int SCL_DIV   = 100;
  localparam int SCL_SHIFT = Y_W;
  localparam int SCL_RECIP = (1 << SCL_SHIFT) / SCL_DIV;
  localparam int SREC_W    = 16;
  localparam int Q_W       = 16;
  localparam int PCM_POS_MAX = 32767;
  localparam int PCM_NEG_MAG = 32768;

  // Run control
  localparam int CNT_W   = 4;
  localparam int MAX_RUN = 12;

  typedef struct packed {
    logic             sixteen_bit;
    logic             stereo;
    logic [SRC_W-1:0] source_rate;
    logic [VOL_W-1:0] volume_percent;
    logic [FRM_W-1:0] total_frames;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic win_mul;
    logic win_fix;
    logic gain_init;
    logic div_step;
    logic vg_mul;
    logic smp_mul;
    logic rec_mul;
    logic rec_fix;
    logic load;
    logic last;
    logic drop;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic gain_full;
    logic ph_below;
    logic nxt_below;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpr_regs.sv =====
// Configuration register file with its APB-style access port
`timescale 1ns / 1ps
`default_nettype none

module wpr_regs import wpr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output cfg_t                   cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;
  cfg_t                 cfg_r;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[ADDR_W-1:2];
  assign cfg = cfg_r;

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sixteen_bit    <= 1'b1;
      cfg_r.stereo         <= 1'b1;
      cfg_r.source_rate    <= SRC_W'(SRC_RATE_RST);
      cfg_r.volume_percent <= VOL_W'(VOLUME_RST);
      cfg_r.total_frames   <= '0;
    end else if (wr) begin
      case (idx)
        REG_SIXTEEN_BIT:  cfg_r.sixteen_bit    <= pwdata[0];
        REG_STEREO:       cfg_r.stereo         <= pwdata[0];
        REG_SOURCE_RATE:  cfg_r.source_rate    <= pwdata[SRC_W-1:0];
        REG_VOLUME:       cfg_r.volume_percent <= pwdata[VOL_W-1:0];
        REG_TOTAL_FRAMES: cfg_r.total_frames   <= pwdata[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_SIXTEEN_BIT:  prdata = DATA_W'(cfg_r.sixteen_bit);
      REG_STEREO:       prdata = DATA_W'(cfg_r.stereo);
      REG_SOURCE_RATE:  prdata = DATA_W'(cfg_r.source_rate);
      REG_VOLUME:       prdata = DATA_W'(cfg_r.volume_percent);
      REG_TOTAL_FRAMES: prdata = DATA_W'(cfg_r.total_frames);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/wpr_ctrl.sv =====
// Controller state machine that sequences one source word through the datapath
`timescale 1ns / 1ps
`default_nettype none

module wpr_ctrl import wpr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_WIN_MUL   = 4'd1;
  localparam logic [3:0] ST_WIN_FIX   = 4'd2;
  localparam logic [3:0] ST_GAIN_INIT = 4'd3;
  localparam logic [3:0] ST_DIV       = 4'd4;
  localparam logic [3:0] ST_VG        = 4'd5;
  localparam logic [3:0] ST_SMP_MUL   = 4'd6;
  localparam logic [3:0] ST_REC_MUL   = 4'd7;
  localparam logic [3:0] ST_REC_FIX   = 4'd8;
  localparam logic [3:0] ST_EMIT      = 4'd9;
  localparam logic [3:0] ST_DROP      = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Advance the sequence and issue at most one command per step
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_WIN_MUL;
        end
      end
      ST_WIN_MUL: begin
        cmd.win_mul = 1'b1;
        state_nxt   = ST_WIN_FIX;
      end
      ST_WIN_FIX: begin
        cmd.win_fix = 1'b1;
        state_nxt   = ST_GAIN_INIT;
      end
      ST_GAIN_INIT: begin
        cmd.gain_init = 1'b1;
        if (stat.gain_full) begin
          state_nxt = ST_VG;
        end else begin
          state_nxt = ST_DIV;
          cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_VG;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_VG: begin
        cmd.vg_mul = 1'b1;
        state_nxt  = ST_SMP_MUL;
      end
      ST_SMP_MUL: begin
        cmd.smp_mul = 1'b1;
        state_nxt   = ST_REC_MUL;
      end
      ST_REC_MUL: begin
        cmd.rec_mul = 1'b1;
        state_nxt   = ST_REC_FIX;
      end
      ST_REC_FIX: begin
        cmd.rec_fix = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the sample for each output slot while the phase is below the rate, up to MAX_RUN slots
        if (stat.ph_below && (cnt_r < CNT_W'(MAX_RUN))) begin
          if (stat.out_free) begin
            cmd.load = 1'b1;
            cmd.last = !(stat.nxt_below && (cnt_r < CNT_W'(MAX_RUN - 1)));
            cnt_nxt  = cnt_r + CNT_W'(1);
            if (cmd.last) begin
              state_nxt = ST_DROP;
            end
          end
        end else begin
          state_nxt = ST_DROP;
        end
      end
      ST_DROP: begin
        cmd.drop  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wpr_dp.sv =====
// Datapath: decode, fade gain divider, scaling, phase accumulator, output register
`timescale 1ns / 1ps
`default_nettype none

module wpr_dp import wpr_pkg::*; #(
  parameter int OUTPUT_RATE = OUTPUT_RATE_DEF,
  parameter int FADE_MS     = FADE_MS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire cmd_t                    cmd,
  output stat_t                        stat,
  input  wire logic        [RAW_W-1:0] in_raw_frame,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed      [PCM_W-1:0] out_pcm_left,
  output logic signed      [PCM_W-1:0] out_pcm_right,
  output logic             [LVL_W-1:0] out_left_level,
  output logic             [LVL_W-1:0] out_right_level,
  output logic                         out_last_of_run
);

  localparam logic [PHASE_W-1:0] RATE_C = PHASE_W'(OUTPUT_RATE);
  localparam logic [FADE_W-1:0]  FADE_C = FADE_W'(FADE_MS);

  // Magnitude of a signed sample
  function automatic logic [MAG_W-1:0] smp_abs(input logic [PCM_W-1:0] s);
    smp_abs = s[PCM_W-1] ? (MAG_W'(~s) + MAG_W'(1)) : MAG_W'(s);
  endfunction

  // Correct the reciprocal quotient, restore the sign and saturate
  function automatic logic [PCM_W-1:0] scl_fix(input logic [Y_W-1:0] y,
                                               input logic [Q_W-1:0] q0,
                                               input logic           neg);
    logic [Y_W-1:0] back;
    logic [Y_W-1:0] rem;
    logic [Q_W-1:0] q;
    back = Y_W'(q0) * Y_W'(SCL_DIV);
    rem  = y - back;
    q    = q0 + Q_W'(rem >= Y_W'(SCL_DIV));
    if (neg) begin
      scl_fix = (q > Q_W'(PCM_NEG_MAG)) ? PCM_W'(PCM_NEG_MAG)
                                        : PCM_W'(Q_W'(~q) + Q_W'(1));
    end else begin
      scl_fix = (q > Q_W'(PCM_POS_MAX)) ? PCM_W'(PCM_POS_MAX) : PCM_W'(q);
    end
  endfunction

  logic [PCM_W-1:0]   smp_l, smp_r;
  logic               neg_l_r, neg_r_r;
  logic [MAG_W-1:0]   mag_l_r, mag_r_r;
  logic [FRM_W-1:0]   fc_r;
  logic [FRM_W-1:0]   fl_r;
  logic [WPROD_W-1:0] wprod_r;
  logic [WPROD_W+WREC_W-1:0] wq_full;
  logic [WIN_W-1:0]   wq0_r;
  logic [WPROD_W-1:0] wq_back, wrem;
  logic [WIN_W-1:0]   win_r;
  logic [WIN_W-1:0]   rem_r;
  logic [WIN_W:0]     dshift;
  logic               dge;
  logic [GAIN_W-1:0]  gain_r;
  logic [VOL_W+GAIN_W-1:0] vg_full;
  logic [VG_W-1:0]    vg_r;
  logic [MAG_W+VG_W-1:0] prod_full_l, prod_full_r;
  logic [PROD_W-1:0]  prod_l_r, prod_r_r;
  logic [Y_W+SREC_W-1:0] qf_l, qf_r;
  logic [Y_W-1:0]     y_l_r, y_r_r;
  logic [Q_W-1:0]     q0_l_r, q0_r_r;
  logic [PCM_W-1:0]   pcm_l_r, pcm_r_r;
  logic [PHASE_W-1:0] phase_r, phase_sum;
  logic               out_valid_r;

  // Decode the source word; mono copies the left channel
  always_comb begin
    if (cfg.sixteen_bit) begin
      smp_l = in_raw_frame[15:0];
      smp_r = cfg.stereo ? in_raw_frame[31:16] : in_raw_frame[15:0];
    end else begin
      smp_l = {~in_raw_frame[7], in_raw_frame[6:0], 8'h00};
      smp_r = cfg.stereo ? {~in_raw_frame[15], in_raw_frame[14:8], 8'h00}
                         : {~in_raw_frame[7], in_raw_frame[6:0], 8'h00};
    end
  end

  // Window by reciprocal multiply and one correction step
  assign wq_full = wprod_r * WREC_W'(WIN_RECIP);
  assign wq_back = WPROD_W'(wq0_r) * WPROD_W'(MS_PER_S);
  assign wrem    = wprod_r - wq_back;

  // One restoring division step of frames_left * 256 / window
  assign dshift = {rem_r, 1'b0};
  assign dge    = (dshift >= {1'b0, win_r});

  assign vg_full     = cfg.volume_percent * gain_r;
  assign prod_full_l = mag_l_r * vg_r;
  assign prod_full_r = mag_r_r * vg_r;
  assign qf_l = prod_l_r[PROD_W-1:LO_SHIFT] * SREC_W'(SCL_RECIP);
  assign qf_r = prod_r_r[PROD_W-1:LO_SHIFT] * SREC_W'(SCL_RECIP);

  assign phase_sum = phase_r + PHASE_W'(cfg.source_rate);

  assign stat.gain_full = (win_r == '0) || (fl_r >= FRM_W'(win_r));
  assign stat.ph_below  = (phase_r < RATE_C);
  assign stat.nxt_below = (phase_sum < RATE_C);
  assign stat.out_free  = !out_valid_r || !out_stall;

  // Count consumed frames, saturating at the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
    end else if (cmd.accept && (fc_r != '1)) begin
      fc_r <= fc_r + FRM_W'(1);
    end
  end

  // Capture samples and run the per-word arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      neg_l_r <= smp_l[PCM_W-1];
      neg_r_r <= smp_r[PCM_W-1];
      mag_l_r <= smp_abs(smp_l);
      mag_r_r <= smp_abs(smp_r);
      wprod_r <= cfg.source_rate * FADE_C;
    end
    if (cmd.win_mul) begin
      wq0_r <= wq_full[WIN_SHIFT+WIN_W-1:WIN_SHIFT];
      fl_r  <= (cfg.total_frames > fc_r) ? (cfg.total_frames - fc_r) : '0;
    end
    if (cmd.win_fix) begin
      win_r <= wq0_r + WIN_W'(wrem >= WPROD_W'(MS_PER_S));
    end
    if (cmd.gain_init) begin
      gain_r <= stat.gain_full ? GAIN_W'(GAIN_FULL) : '0;
      rem_r  <= fl_r[WIN_W-1:0];
    end else if (cmd.div_step) begin
      gain_r <= {gain_r[GAIN_W-2:0], dge};
      rem_r  <= dge ? WIN_W'(dshift - {1'b0, win_r}) : dshift[WIN_W-1:0];
    end
    if (cmd.vg_mul) begin
      vg_r <= vg_full[VG_W-1:0];
    end
    if (cmd.smp_mul) begin
      prod_l_r <= prod_full_l[PROD_W-1:0];
      prod_r_r <= prod_full_r[PROD_W-1:0];
    end
    if (cmd.rec_mul) begin
      y_l_r  <= prod_l_r[PROD_W-1:LO_SHIFT];
      y_r_r  <= prod_r_r[PROD_W-1:LO_SHIFT];
      q0_l_r <= qf_l[SCL_SHIFT+Q_W-1:SCL_SHIFT];
      q0_r_r <= qf_r[SCL_SHIFT+Q_W-1:SCL_SHIFT];
    end
    if (cmd.rec_fix) begin
      pcm_l_r <= scl_fix(y_l_r, q0_l_r, neg_l_r);
      pcm_r_r <= scl_fix(y_r_r, q0_r_r, neg_r_r);
    end
  end

  // Advance the phase per output word, drop by the output rate at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.load) begin
      phase_r <= phase_sum;
    end else if (cmd.drop && !stat.ph_below) begin
      phase_r <= phase_r - RATE_C;
    end
  end

  // Output register: load a word, clear valid once it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_pcm_left    <= pcm_l_r;
      out_pcm_right   <= pcm_r_r;
      out_left_level  <= {~pcm_l_r[PCM_W-1], pcm_l_r[PCM_W-2:LVL_W]};
      out_right_level <= {~pcm_r_r[PCM_W-1], pcm_r_r[PCM_W-2:LVL_W]};
      out_last_of_run <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/wav_pcm_resample_to_pwm_unit.sv =====
// Top level of the WAV PCM resampler to PWM levels.
// An accepted source word runs through the window, gain, scaling and emit states;
// the 8-step gain divider runs only while the gain is below full. The emit loop gives
// one output word per cycle unless out_stall holds it; in_stall stays high until the
// controller is idle again, so a new source word waits for all outputs of the last.
// Reset: synchronous active-low rst_n; clears phase, frame count, controller and valid.
`timescale 1ns / 1ps
`default_nettype none
`include "wav_pcm_resample_to_pwm_unit_defines.svh"

module wav_pcm_resample_to_pwm_unit import wpr_pkg::*; #(
  parameter int OUTPUT_RATE = OUTPUT_RATE_DEF,
  parameter int FADE_MS     = FADE_MS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic        [RAW_W-1:0] in_raw_frame,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed      [PCM_W-1:0] out_pcm_left,
  output logic signed      [PCM_W-1:0] out_pcm_right,
  output logic             [LVL_W-1:0] out_left_level,
  output logic             [LVL_W-1:0] out_right_level,
  output logic                         out_last_of_run,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic       [ADDR_W-1:0] paddr,
  input  wire logic       [DATA_W-1:0] pwdata,
  output logic            [DATA_W-1:0] prdata,
  output logic                         pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  wpr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  wpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wpr_dp #(
    .OUTPUT_RATE (OUTPUT_RATE),
    .FADE_MS     (FADE_MS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .in_raw_frame    (in_raw_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pcm_left    (out_pcm_left),
    .out_pcm_right   (out_pcm_right),
    .out_left_level  (out_left_level),
    .out_right_level (out_right_level),
    .out_last_of_run (out_last_of_run)
  );

  // Busy right after taking a source word
  `WPR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // A taken word that is not the last of its run is followed at once by the next
  `WPR_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && !out_stall && !out_last_of_run, out_valid)
  // While ready for input, any waiting word closes its run
  `WPR_ASSERT_SAME(a_idle_holds_last, clk, rst_n, !in_stall && out_valid, out_last_of_run)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the WAV PCM resampler to PWM levels
`timescale 1ns / 1ps

module testbench;
  import wpr_pkg::*;

  localparam int OUT_RATE      = OUTPUT_RATE_DEF;
  localparam int SETTLE_CYCLES = 48;
  localparam int QUIET_LIMIT   = 5000;

  // One output word as the block presents it
  typedef struct packed {
    logic signed [PCM_W-1:0] pcm_left;
    logic signed [PCM_W-1:0] pcm_right;
    logic [LVL_W-1:0]        left_level;
    logic [LVL_W-1:0]        right_level;
    logic                    last_of_run;
  } pwm_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [RAW_W-1:0] in_raw_frame = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PCM_W-1:0] out_pcm_left;
  logic signed [PCM_W-1:0] out_pcm_right;
  logic [LVL_W-1:0] out_left_level;
  logic [LVL_W-1:0] out_right_level;
  logic out_last_of_run;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Shadow of the register file and the resampler state
  logic             fmt_sixteen = 1'b1;
  logic             fmt_stereo  = 1'b1;
  logic [SRC_W-1:0] src_rate    = SRC_W'(SRC_RATE_RST);
  logic [VOL_W-1:0] vol_pct     = VOL_W'(VOLUME_RST);
  logic [FRM_W-1:0] total_frm   = '0;
  logic [PHASE_W-1:0] phase_acc = '0;
  logic [FRM_W-1:0] frames_done = '0;

  pwm_word_t pending_words[$];
  pwm_word_t exp_w;
  int errors = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  wav_pcm_resample_to_pwm_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_frame   (in_raw_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pcm_left   (out_pcm_left),
    .out_pcm_right  (out_pcm_right),
    .out_left_level (out_left_level),
    .out_right_level(out_right_level),
    .out_last_of_run(out_last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Pull one channel out of the raw frame as a signed 16-bit sample
  function automatic int decode_channel(input logic [RAW_W-1:0] raw, input int ch);
    logic [15:0] w16;
    logic [7:0]  b8;
    w16 = raw[16*ch +: 16];
    b8  = raw[8*ch +: 8];
    if (fmt_sixteen) return int'($signed(w16));
    return (int'(b8) - 128) * 256;
  endfunction

  // Apply volume and tail gain, truncate toward zero, saturate to 16 bits
  function automatic int scale_sample(input int s, input int unsigned gain);
    longint prod, mag, q;
    prod = longint'(s) * longint'(vol_pct) * longint'(gain);
    mag = (prod < 0) ? -prod : prod;
    q = mag / (GAIN_FULL * SCL_DIV);
    if (prod < 0) q = -q;
    if (q > PCM_POS_MAX) q = PCM_POS_MAX;
    if (q < -PCM_NEG_MAG) q = -PCM_NEG_MAG;
    return int'(q);
  endfunction

  // Offset the sample high byte around mid-scale
  function automatic logic [LVL_W-1:0] level_of(input int s);
    int v;
    v = (s + PCM_NEG_MAG) >>> 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[LVL_W-1:0];
  endfunction

  // Advance the shadow state by one source frame and queue its output words
  function automatic void resample_frame(input logic [RAW_W-1:0] raw);
    int left_s, right_s, pl, pr, n;
    longint unsigned win, g, frames_left;
    int unsigned gain;
    logic [PHASE_W-1:0] nxt;
    pwm_word_t w;
    left_s  = decode_channel(raw, 0);
    right_s = fmt_stereo ? decode_channel(raw, 1) : left_s;
    if (frames_done != '1) frames_done++;
    frames_left = (total_frm > frames_done) ? 64'(total_frm - frames_done) : '0;
    win = 64'(src_rate);
    win = win * FADE_MS_DEF / MS_PER_S;
    if (win == 0) begin
      gain = GAIN_FULL;
    end else begin
      g = frames_left * GAIN_FULL / win;
      gain = (g > GAIN_FULL) ? GAIN_FULL : 32'(g);
    end
    pl = scale_sample(left_s, gain);
    pr = scale_sample(right_s, gain);
    // Hold this frame for as many output slots as the phase allows, up to MAX_RUN
    n = 0;
    while (phase_acc < OUT_RATE && n < MAX_RUN) begin
      nxt = phase_acc + PHASE_W'(src_rate);
      w.pcm_left    = pl[PCM_W-1:0];
      w.pcm_right   = pr[PCM_W-1:0];
      w.left_level  = level_of(pl);
      w.right_level = level_of(pr);
      w.last_of_run = !(nxt < OUT_RATE && n < MAX_RUN - 1);
      pending_words.push_back(w);
      n++;
      phase_acc = nxt;
    end
    if (phase_acc >= OUT_RATE) phase_acc = phase_acc - PHASE_W'(OUT_RATE);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare each accepted output word with the oldest expected one; randomize stall
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        check_field("pcm_left", exp_w.pcm_left, out_pcm_left);
        check_field("pcm_right", exp_w.pcm_right, out_pcm_right);
        check_field("left_level", 16'(exp_w.left_level), 16'(out_left_level));
        check_field("right_level", 16'(exp_w.right_level), 16'(out_right_level));
        check_field("last_of_run", 16'(exp_w.last_of_run), 16'(out_last_of_run));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Count cycles in which no word or register access moves
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  // Send one source word, with a random gap ahead of it
  task automatic send_frame(input logic [RAW_W-1:0] raw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_frame <= raw;
    do @(posedge clk); while (in_stall !== 1'b0);
    resample_frame(raw);
  endtask

  // Drop valid, wait for all expected words, then let skipped frames finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register once the block is idle and mirror it in the shadow
  task automatic apply_config(input logic sb, input logic st, input logic [SRC_W-1:0] rate,
                              input logic [VOL_W-1:0] vol, input logic [FRM_W-1:0] total);
    settle();
    write_reg(REG_SIXTEEN_BIT, DATA_W'(sb));
    write_reg(REG_STEREO, DATA_W'(st));
    write_reg(REG_SOURCE_RATE, DATA_W'(rate));
    write_reg(REG_VOLUME, DATA_W'(vol));
    write_reg(REG_TOTAL_FRAMES, DATA_W'(total));
    fmt_sixteen = sb;
    fmt_stereo  = st;
    src_rate    = rate;
    vol_pct     = vol;
    total_frm   = total;
  endtask

  // Reset values: no frames in the stream, so the output is silent
  task automatic test_power_on();
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h0000_0000);
  endtask

  // Every sample format at full volume, one output per frame
  task automatic test_sample_formats();
    apply_config(1'b1, 1'b1, 17'd44100, 7'd100, '1);
    send_frame(32'h7FFF_8000);
    send_frame(32'h8000_7FFF);
    apply_config(1'b1, 1'b0, 17'd44100, 7'd100, '1);
    send_frame(32'hFFFF_0001);
    send_frame(32'h0000_8000);
    apply_config(1'b0, 1'b1, 17'd44100, 7'd100, '1);
    send_frame(32'h0000_FF00);
    send_frame(32'hFFFF_00FF);
    apply_config(1'b0, 1'b0, 17'd44100, 7'd100, '1);
    send_frame(32'hFFFF_FF00);
    send_frame(32'h0000_00FF);
  endtask

  // Volume above 100 saturates; volume zero mutes
  task automatic test_volume_clip();
    apply_config(1'b1, 1'b1, 17'd44100, 7'd127, '1);
    send_frame(32'h7FFF_8000);
    send_frame(32'h8000_7FFF);
    apply_config(1'b1, 1'b1, 17'd44100, 7'd0, '1);
    send_frame(32'h7FFF_7FFF);
  endtask

  // Tiny source rates: zero fade window gives full gain, window 1 mutes, runs cap at MAX_RUN
  task automatic test_zero_window();
    apply_config(1'b1, 1'b1, 17'd199, 7'd100, '0);
    send_frame(32'h4000_C000);
    apply_config(1'b1, 1'b1, 17'd0, 7'd100, '0);
    send_frame(32'h8001_7FFE);
    apply_config(1'b1, 1'b1, 17'd200, 7'd100, '0);
    send_frame(32'h7FFF_8000);
  endtask

  // Fade the last frames of the stream down to silence, then run past the end
  task automatic test_fade_tail();
    apply_config(1'b1, 1'b1, 17'd44100, 7'd100, frames_done + 2);
    send_frame(32'h7FFF_8000);
    send_frame(32'h7FFF_8000);
    send_frame(32'h1234_5678);
    apply_config(1'b1, 1'b1, 17'd96000, 7'd100, frames_done + 300);
    send_frame(32'h7FFF_8000);
    send_frame(32'h8000_7FFF);
  endtask

  // Source faster than the output: frames get skipped
  task automatic test_fast_source();
    apply_config(1'b1, 1'b1, 17'd131071, 7'd100, '1);
    send_frame(32'h0102_0304);
    send_frame(32'hF0E0_D0C0);
    send_frame(32'h5555_AAAA);
    send_frame(32'hAAAA_5555);
  endtask

  // Random settings and frames, draining before each new setting and once more half way through
  task automatic test_random_stream(input int n_items);
    int sent;
    bit paused;
    logic [SRC_W-1:0] rate;
    logic [VOL_W-1:0] vol;
    logic [FRM_W-1:0] total;
    logic [RAW_W-1:0] raw;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       rate = '0;
        1:       rate = SRC_W'($urandom_range(199));
        2:       rate = SRC_W'($urandom_range(131071, 96001));
        3:       rate = 17'd44100;
        default: rate = SRC_W'($urandom_range(96000, 4000));
      endcase
      vol = ($urandom_range(9) == 0) ? VOL_W'($urandom_range(127, 101))
                                     : VOL_W'($urandom_range(100));
      case ($urandom_range(7))
        0:       total = '0;
        1:       total = '1;
        2:       total = $urandom;
        default: total = frames_done + $urandom_range(600);
      endcase
      apply_config(1'($urandom_range(1)), 1'($urandom_range(1)), rate, vol, total);
      repeat ($urandom_range(28, 12)) begin
        case ($urandom_range(7))
          0:       raw = '0;
          1:       raw = '1;
          default: raw = $urandom;
        endcase
        send_frame(raw);
        sent++;
        if (!paused && sent >= n_items / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin
    send_gap_pct = 6;
    stall_pct = 50;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on();
    test_sample_formats();
    test_volume_clip();
    test_zero_window();
    test_fade_tail();
    test_fast_source();
    test_random_stream(100);
    send_gap_pct = 50;
    stall_pct = 6;
    test_random_stream(100);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_stream(100);
    settle();
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== wav_pcm_resample_to_pwm_unit.f =====
+incdir+rtl/core
rtl/core/wpr_pkg.sv
rtl/core/wpr_regs.sv
rtl/core/wpr_ctrl.sv
rtl/core/wpr_dp.sv
rtl/core/wav_pcm_resample_to_pwm_unit.sv
tb/testbench.sv
